[src/assert_macros.svh]
// Assertion macros used by the RTL of the capacity-checked queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define CCFR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CCFR_ASSERT(lbl, clk, rst, prop, msg)
`define CCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[src/ccfr_pkg.sv]
// Shared types and codes of the capacity-checked queue.
`default_nettype none

package ccfr_pkg;

   typedef logic [15:0] word_type;
   typedef logic [1:0]  kind_type;
   typedef logic [2:0]  status_type;

   // request kinds
   localparam kind_type KIND_ENQ   = 2'd0;
   localparam kind_type KIND_DEQ   = 2'd1;
   localparam kind_type KIND_REM   = 2'd2;
   localparam kind_type KIND_FLUSH = 2'd3;

   // result status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_TOO_LARGE = 3'd1;
   localparam status_type ST_EMPTY     = 3'd2;
   localparam status_type ST_NO_FIT    = 3'd3;
   localparam status_type ST_NOT_FOUND = 3'd4;
   localparam status_type ST_FULL      = 3'd5;

   // capacity register value after reset
   localparam word_type CAP_RESET = 16'd1024;

endpackage

`default_nettype wire

[src/ccfr_if.sv]
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface ccfr_req_if;
   import ccfr_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   word_type entry_id;
   word_type entry_size;
   word_type offered_amount;

   modport source (output valid, kind, entry_id, entry_size, offered_amount, input ready);
   modport sink   (input valid, kind, entry_id, entry_size, offered_amount, output ready);
endinterface

interface ccfr_rsp_if;
   import ccfr_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   word_type   out_id;
   word_type   out_size;
   word_type   budget_left;

   modport source (output valid, status, out_id, out_size, budget_left, input ready);
   modport sink   (input valid, status, out_id, out_size, budget_left, output ready);
endinterface

`default_nettype wire

[src/capacity_checked_fifo_with_removal_core.sv]
// Top level: ordered (id, size) queue with capacity budget, pop-if-fits and removal by id.
`default_nettype none
`include "assert_macros.svh"

// Requests are taken one at a time; the next request is accepted while the previous
// response still waits in the output register. Entries live in one synchronous memory
// kept in queue order, oldest at address 0, read at most once per cycle. Enqueue and
// flush go from accept through the execute state to the response. Dequeue looks at the
// head entry only; remove scans from the head until the id matches. On a hit every
// younger entry moves down one place to close the gap, and the entry's size goes back
// to the budget. A remove that finds nothing answers not found. The capacity register
// feeds the budget only at reset and on flush.
module capacity_checked_fifo_with_removal_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  ccfr_pkg::word_type csr_wdata,
   ccfr_req_if.sink          req_bus,
   ccfr_rsp_if.source        rsp_bus
);
   import ccfr_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   // control state
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   word_type      budget_ff, budget_in;
   word_type      cap_ff;
   logic [CW-1:0] scan_ff, scan_in;
   logic [AW-1:0] chk_ff, chk_in;
   logic          chkv_ff, chkv_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // request and result payload
   kind_type   op_ff;
   word_type   id_ff, size_ff, offer_ff;
   status_type st_ff, st_in;
   word_type   oid_ff, oid_in, osz_ff, osz_in;
   status_type rsp_st_ff;
   word_type   rsp_id_ff, rsp_sz_ff, rsp_bl_ff;

   // entry memory ports
   word_type      mem_id [QUEUE_DEPTH];
   word_type      mem_sz [QUEUE_DEPTH];
   word_type      rd_id_ff, rd_sz_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   word_type      wr_id, wr_sz;

   logic          req_beat;
   logic [16:0]   give_sum;

   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign req_beat      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_st_ff;
   assign rsp_bus.out_id      = rsp_id_ff;
   assign rsp_bus.out_size    = rsp_sz_ff;
   assign rsp_bus.budget_left = rsp_bl_ff;

   // budget give-back saturates at full scale
   assign give_sum = {1'b0, budget_ff} + {1'b0, osz_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      budget_in    = budget_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      chkv_in      = chkv_ff;
      st_in        = st_ff;
      oid_in       = oid_ff;
      osz_in       = osz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_en        = 1'b0;
      rd_addr      = scan_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_id        = id_ff;
      wr_sz        = size_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) state_in = S_EXEC;
         end

         S_EXEC: begin
            st_in   = ST_OK;
            oid_in  = '0;
            osz_in  = '0;
            scan_in = '0;
            chkv_in = 1'b0;
            state_in = S_RESP;
            case (op_ff)
               KIND_ENQ: begin
                  if (size_ff > budget_ff) begin
                     st_in = ST_TOO_LARGE;
                  end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                     st_in = ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + 1'b1;
                     budget_in = budget_ff - size_ff;
                  end
               end
               KIND_DEQ: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else                state_in = S_SEARCH;
               end
               KIND_REM: begin
                  state_in = S_SEARCH;
               end
               default: begin
                  count_in  = '0;
                  budget_in = cap_ff;
               end
            endcase
         end

         // walk from the head, one read a cycle, compare in the cycle after the read
         S_SEARCH: begin
            rd_en   = (scan_ff < count_ff);
            chkv_in = rd_en;
            if (rd_en) begin
               chk_in  = scan_ff[AW-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (chkv_ff) begin
               if ((op_ff == KIND_DEQ) ? (offer_ff > rd_sz_ff) : (rd_id_ff == id_ff)) begin
                  oid_in   = rd_id_ff;
                  osz_in   = rd_sz_ff;
                  scan_in  = CW'(chk_ff) + 1'b1;
                  chkv_in  = 1'b0;
                  state_in = S_SHIFT;
               end else if (op_ff == KIND_DEQ) begin
                  st_in    = ST_NO_FIT;
                  state_in = S_RESP;
               end
            end else if (!rd_en) begin
               st_in    = ST_NOT_FOUND;
               state_in = S_RESP;
            end
         end

         // move younger entries down one place over the removed one
         S_SHIFT: begin
            rd_en   = (scan_ff < count_ff);
            chkv_in = rd_en;
            if (rd_en) begin
               chk_in  = scan_ff[AW-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (chkv_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff - 1'b1;
               wr_id   = rd_id_ff;
               wr_sz   = rd_sz_ff;
            end else if (!rd_en) begin
               count_in  = count_ff - 1'b1;
               budget_in = give_sum[16] ? 16'hFFFF : give_sum[15:0];
               st_in     = ST_OK;
               state_in  = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         budget_ff    <= CAP_RESET;
         cap_ff       <= CAP_RESET;
         scan_ff      <= '0;
         chk_ff       <= '0;
         chkv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         budget_ff    <= budget_in;
         scan_ff      <= scan_in;
         chk_ff       <= chk_in;
         chkv_ff      <= chkv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) cap_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff    <= req_bus.kind;
         id_ff    <= req_bus.entry_id;
         size_ff  <= req_bus.entry_size;
         offer_ff <= req_bus.offered_amount;
      end
      st_ff  <= st_in;
      oid_ff <= oid_in;
      osz_ff <= osz_in;
      if (state_ff == S_RESP && !(rsp_valid_ff && !rsp_bus.ready)) begin
         rsp_st_ff <= st_ff;
         rsp_id_ff <= oid_ff;
         rsp_sz_ff <= osz_ff;
         rsp_bl_ff <= budget_ff;
      end
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_id[wr_addr] <= wr_id;
         mem_sz[wr_addr] <= wr_sz;
      end
      if (rd_en) begin
         rd_id_ff <= mem_id[rd_addr];
         rd_sz_ff <= mem_sz[rd_addr];
      end
   end

   // checks
   `CCFR_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "entry count above depth")
   `CCFR_ASSERT_NEXT(a_beat_exec, clock, reset, req_beat, state_ff == S_EXEC, "accepted beat not executed")
   `CCFR_ASSERT(a_shift_range, clock, reset, !(state_ff == S_SHIFT && chkv_ff) || (CW'(chk_ff) < count_ff && chk_ff != '0), "shift write outside queue")

endmodule

`default_nettype wire
